@@ rtl/ncnt_pkg.sv @@
package ncnt_pkg;

  localparam int ValueW      = 32;
  localparam int TokenW      = 4;
  localparam int DigitW      = 4;
  localparam int NumDigits   = 10;
  localparam int BcdW        = NumDigits * DigitW;
  localparam int PosW        = 4;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = ValueW / BitsPerStep;
  localparam int ConvCntW    = $clog2(ConvSteps);

  localparam logic [TokenW-1:0] TOK_ZERO = 4'd0;
  localparam logic [TokenW-1:0] TOK_TEN  = 4'd10;
  localparam logic [TokenW-1:0] TOK_WAN  = 4'd13;
  localparam logic [TokenW-1:0] TOK_YI   = 4'd14;

  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_UNIT  = 2'd2;
  localparam logic [1:0] KIND_GWORD = 2'd3;

  typedef struct packed {
    logic            load;
    logic            conv;
    logic            emit;
    logic [1:0]      kind;
    logic [PosW-1:0] pos;
  } ncnt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic digit_nz;
    logic group_nz;
  } ncnt_status_t;

endpackage

@@ rtl/ncnt_value_if.sv @@
interface ncnt_value_if import ncnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/ncnt_token_if.sv @@
interface ncnt_token_if import ncnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TokenW-1:0] token;
  logic              last;

  modport source (output valid, output token, output last, input ready);
  modport sink   (input valid, input token, input last, output ready);
endinterface

@@ rtl/number_to_chinese_numeral_tokens_top.sv @@
// Spells a 32-bit unsigned value as Chinese numeral tokens, most significant
// first, with last set on the final token; a value of zero produces no tokens.
// One value is in flight at a time: the transfer cycle loads it, then the
// converter turns it into ten decimal digits (four bits per cycle), and the
// digit sequencer walks the ten places from the most significant, emitting
// a glyph for each nonzero digit with its place unit where it has one, and a
// group word after each nonzero upper group; a zero token goes out while the
// sequencer is at the place of the nonzero digit that follows it. Emitting
// waits while the output side stalls. The final token may still wait in the
// output register while the next value is taken.
module number_to_chinese_numeral_tokens_top import ncnt_pkg::*; (
  input logic         clk,
  input logic         rst,
  ncnt_value_if.sink  value_in,
  ncnt_token_if.source token_out
);

  ncnt_cmd_t    cmd;
  ncnt_status_t status;

  ncnt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (value_in.valid),
    .in_ready (value_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ncnt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value_in.value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .token     (token_out.token),
    .last      (token_out.last)
  );

endmodule

@@ rtl/ncnt_datapath.sv @@
module ncnt_datapath import ncnt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ValueW-1:0] value,
  input  ncnt_cmd_t         cmd,
  output ncnt_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TokenW-1:0] token,
  output logic              last
);

  logic [ValueW-1:0] bin;
  logic [ValueW-1:0] bin_next;
  logic [BcdW-1:0]   bcd;
  logic [BcdW-1:0]   bcd_next;
  logic [DigitW-1:0] dig [NumDigits];
  logic [NumDigits-1:0] nz;
  logic              group_nz;
  logic              rest_zero;
  logic [DigitW-1:0] cur_digit;
  logic [TokenW-1:0] tok_sel;
  logic              last_sel;

  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int k = 0; k < BitsPerStep; k++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (bcd_next[i*DigitW +: DigitW] >= 4'd5) begin
          bcd_next[i*DigitW +: DigitW] = bcd_next[i*DigitW +: DigitW] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BcdW-2:0], bin_next[ValueW-1]};
      bin_next = {bin_next[ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
    end else if (cmd.conv) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

  always_comb begin
    group_nz  = 1'b0;
    rest_zero = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      dig[i] = bcd[i*DigitW +: DigitW];
      nz[i]  = |bcd[i*DigitW +: DigitW];
    end
    for (int i = 0; i < NumDigits; i++) begin
      if (PosW'(i) >> 2 == cmd.pos >> 2) begin
        group_nz = group_nz | nz[i];
      end
      if (PosW'(i) < cmd.pos) begin
        rest_zero = rest_zero & ~nz[i];
      end
    end
  end

  assign cur_digit = dig[cmd.pos];

  always_comb begin
    case (cmd.kind)
      KIND_ZERO: begin
        tok_sel  = TOK_ZERO;
        last_sel = 1'b0;
      end
      KIND_GLYPH: begin
        tok_sel  = cur_digit;
        last_sel = rest_zero && (cmd.pos == '0);
      end
      KIND_UNIT: begin
        tok_sel  = TOK_TEN - 4'd1 + {2'b00, cmd.pos[1:0]};
        last_sel = rest_zero && (cmd.pos[3:2] == 2'b00);
      end
      KIND_GWORD: begin
        tok_sel  = TOK_WAN - 4'd1 + {2'b00, cmd.pos[3:2]};
        last_sel = rest_zero;
      end
      default: begin
        tok_sel  = TOK_ZERO;
        last_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      token <= tok_sel;
      last  <= last_sel;
    end
  end

  assign status.out_free = ~out_valid | out_ready;
  assign status.digit_nz = |cur_digit;
  assign status.group_nz = group_nz;

endmodule

@@ rtl/ncnt_controller.sv @@
module ncnt_controller import ncnt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ncnt_status_t status,
  output ncnt_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_GLYPH = 3'd3;
  localparam logic [2:0] S_UNIT  = 3'd4;
  localparam logic [2:0] S_GWORD = 3'd5;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [PosW-1:0]     pos;
  logic [PosW-1:0]     pos_next;
  logic [ConvCntW-1:0] cnt;
  logic [ConvCntW-1:0] cnt_next;
  logic                pending;
  logic                pending_next;
  logic                first;
  logic                first_next;

  logic [2:0]      adv_state;
  logic [PosW-1:0] adv_pos;
  logic            adv_clear;

  always_comb begin
    adv_clear = 1'b0;
    adv_state = S_ZERO;
    adv_pos   = pos - 4'd1;
    if (pos[1:0] == 2'b00) begin
      adv_clear = 1'b1;
      if (pos[3:2] != 2'b00 && status.group_nz) begin
        adv_state = S_GWORD;
        adv_pos   = pos;
      end else if (pos == '0) begin
        adv_state = S_IDLE;
        adv_pos   = pos;
      end
    end
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    cnt_next     = cnt;
    pending_next = pending;
    first_next   = first;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.conv     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.kind     = KIND_GLYPH;
    cmd.pos      = pos;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cnt_next     = '0;
          pending_next = 1'b0;
          first_next   = 1'b1;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == ConvCntW'(ConvSteps - 1)) begin
          pos_next   = PosW'(NumDigits - 1);
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.kind = KIND_ZERO;
        if (!status.group_nz || !status.digit_nz) begin
          pending_next = 1'b1;
          if (adv_clear) begin
            pending_next = 1'b0;
          end
          state_next = adv_state;
          pos_next   = adv_pos;
        end else if (pending && !first) begin
          if (status.out_free) begin
            cmd.emit     = 1'b1;
            first_next   = 1'b0;
            pending_next = 1'b0;
            state_next   = S_GLYPH;
          end
        end else begin
          pending_next = 1'b0;
          state_next   = S_GLYPH;
        end
      end
      S_GLYPH: begin
        cmd.kind = KIND_GLYPH;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          first_next = 1'b0;
          if (pos[1:0] != 2'b00) begin
            state_next = S_UNIT;
          end else begin
            if (adv_clear) begin
              pending_next = 1'b0;
            end
            state_next = adv_state;
            pos_next   = adv_pos;
          end
        end
      end
      S_UNIT: begin
        cmd.kind = KIND_UNIT;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          first_next = 1'b0;
          state_next = adv_state;
          pos_next   = adv_pos;
        end
      end
      S_GWORD: begin
        cmd.kind = KIND_GWORD;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          first_next = 1'b0;
          pos_next   = pos - 4'd1;
          state_next = S_ZERO;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      cnt     <= '0;
      pending <= 1'b0;
      first   <= 1'b1;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      cnt     <= cnt_next;
      pending <= pending_next;
      first   <= first_next;
    end
  end

endmodule

@@ rtl/ncnt_checker.sv @@
module ncnt_checker import ncnt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TokenW-1:0] token,
  input logic              last
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token <= TOK_YI)
    else $error("token code out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && token == TOK_ZERO |-> !last)
    else $error("zero glyph ends a run");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second value taken while one is in progress");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token) && $stable(last))
    else $error("stalled token transfer changed");

endmodule

bind number_to_chinese_numeral_tokens_top ncnt_checker u_ncnt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (value_in.valid),
  .in_ready  (value_in.ready),
  .out_valid (token_out.valid),
  .out_ready (token_out.ready),
  .token     (token_out.token),
  .last      (token_out.last)
);
